// ===== src/csvt_pkg.sv =====
// ----------------------------------------------------------------------------
// CSV line tokenizer package
// Shared types, status codes, register indexes and character codes.
// ----------------------------------------------------------------------------
package csvt_pkg;

   // Default width of one character code unit
   localparam int unsigned CHAR_BITS_DEF = 16;

   // Limit register widths
   localparam int unsigned LINE_LIMIT_BITS  = 20;
   localparam int unsigned FIELD_LIMIT_BITS = 16;
   localparam int unsigned COUNT_LIMIT_BITS = 13;

   // Counter widths: one more than the limit so that limit + 1 is representable
   localparam int unsigned LINE_LEN_BITS  = LINE_LIMIT_BITS + 1;
   localparam int unsigned FIELD_LEN_BITS = FIELD_LIMIT_BITS + 1;

   // Configuration port
   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam int unsigned CSR_DATA_BITS  = LINE_LIMIT_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] REG_LINE_LENGTH_LIMIT  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FIELD_LENGTH_LIMIT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FIELD_COUNT_LIMIT  = 2'd2;

   // Limit reset values
   localparam logic [LINE_LIMIT_BITS-1:0]  LINE_LIMIT_RESET  = 20'hFFFFF;
   localparam logic [FIELD_LIMIT_BITS-1:0] FIELD_LIMIT_RESET = 16'hFFFF;
   localparam logic [COUNT_LIMIT_BITS-1:0] COUNT_LIMIT_RESET = 13'd4096;

   // Special characters
   localparam logic [7:0] BACKSLASH_CODE = 8'h5C;
   localparam logic [7:0] QUOTE_CODE     = 8'h22;
   localparam logic [7:0] COMMA_CODE     = 8'h2C;

   // Item kinds
   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_EOL  = 1'b1;

   // Result status
   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_LINE_LONG  = 2'd1,
      ST_FIELD_LONG = 2'd2,
      ST_TOO_MANY   = 2'd3
   } status_type;

endpackage

// ===== src/csvt_req_if.sv =====
// ----------------------------------------------------------------------------
// CSV tokenizer request channel
// Valid/ready channel carrying one character or one end-of-line mark.
// ----------------------------------------------------------------------------
interface csvt_req_if
   import csvt_pkg::*;
#(
   parameter int unsigned CHAR_BITS = CHAR_BITS_DEF
);

   logic                 valid;
   logic                 ready;
   logic                 kind;
   logic [CHAR_BITS-1:0] char_code;

   modport source (output valid, output kind, output char_code, input ready);
   modport sink   (input valid, input kind, input char_code, output ready);

endinterface

// ===== src/csvt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// CSV tokenizer result channel
// Valid/ready channel carrying one tokenizer result.
// ----------------------------------------------------------------------------
interface csvt_rsp_if
   import csvt_pkg::*;
#(
   parameter int unsigned CHAR_BITS = CHAR_BITS_DEF
);

   logic                 valid;
   logic                 ready;
   logic [CHAR_BITS-1:0] out_char;
   logic                 has_char;
   logic                 field_end;
   logic                 line_end;
   status_type           status;

   modport source (output valid, output out_char, output has_char, output field_end,
                   output line_end, output status, input ready);
   modport sink   (input valid, input out_char, input has_char, input field_end,
                   input line_end, input status, output ready);

endinterface

// ===== src/csv_line_tokenizer.sv =====
// ----------------------------------------------------------------------------
// CSV line tokenizer
// Streaming field splitter with quoting, backslash escape and limit checks.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item per transfer: a character (kind = 0, char_code) or
//   an end-of-line mark (kind = 1). rsp carries at most one result per item:
//   a field character, a field end, an error status or the line end.
//   Swallowed quotes/backslashes and characters after an error give no result.
//   csr_wr_en/csr_index/csr_wdata write the three limit registers; write only
//   while the block is idle.
// Timing:
//   One item per cycle unless rsp stalls. A result appears on rsp in the
//   cycle after its request transfer. The line state and the result register
//   are updated in the same cycle, so the next item is taken right away.
// Stall:
//   req.ready stays high while the result register is empty or is being
//   drained in the same cycle; it drops only while a result waits on rsp.
// Reset:
//   Synchronous. Clears the line state and the result valid flag, and
//   loads the length limits with all ones, the field count limit with 4096.
// ----------------------------------------------------------------------------
module csv_line_tokenizer
   import csvt_pkg::*;
#(
   parameter int unsigned CHAR_BITS = CHAR_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   csvt_req_if.sink                    req,
   csvt_rsp_if.source                  rsp,
   input  logic                        csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [CSR_DATA_BITS-1:0]    csr_wdata
);

   // Special characters at the configured width
   localparam logic [CHAR_BITS-1:0] BSL = CHAR_BITS'(BACKSLASH_CODE);
   localparam logic [CHAR_BITS-1:0] QTE = CHAR_BITS'(QUOTE_CODE);
   localparam logic [CHAR_BITS-1:0] CMA = CHAR_BITS'(COMMA_CODE);

   // Limit registers
   logic [LINE_LIMIT_BITS-1:0]  line_limit_ff;
   logic [FIELD_LIMIT_BITS-1:0] field_limit_ff;
   logic [COUNT_LIMIT_BITS-1:0] count_limit_ff;

   // Line state
   logic                        in_quotes_ff,    in_quotes_in;
   logic                        escape_ff,       escape_in;
   logic [FIELD_LEN_BITS-1:0]   field_length_ff, field_length_in;
   logic [LINE_LEN_BITS-1:0]    line_length_ff,  line_length_in;
   logic [COUNT_LIMIT_BITS-1:0] field_count_ff,  field_count_in;
   status_type                  line_error_ff,   line_error_in;

   // Result register
   logic                        rsp_valid_ff,    rsp_valid_in;
   logic [CHAR_BITS-1:0]        out_char_ff,     out_char_in;
   logic                        has_char_ff,     has_char_in;
   logic                        field_end_ff,    field_end_in;
   logic                        line_end_ff,     line_end_in;
   status_type                  status_ff,       status_in;

   logic                        req_fire;
   logic                        emit;

   // Take a new item whenever the result register is free or drains now
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign req_fire  = req.valid && req.ready;

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.out_char  = out_char_ff;
   assign rsp.has_char  = has_char_ff;
   assign rsp.field_end = field_end_ff;
   assign rsp.line_end  = line_end_ff;
   assign rsp.status    = status_ff;

   // ---------------------------------------------------------------------
   // Limit registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         line_limit_ff  <= LINE_LIMIT_RESET;
         field_limit_ff <= FIELD_LIMIT_RESET;
         count_limit_ff <= COUNT_LIMIT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_LINE_LENGTH_LIMIT:  line_limit_ff  <= csr_wdata;
            REG_FIELD_LENGTH_LIMIT: field_limit_ff <= csr_wdata[FIELD_LIMIT_BITS-1:0];
            REG_FIELD_COUNT_LIMIT:  count_limit_ff <= csr_wdata[COUNT_LIMIT_BITS-1:0];
            default: ; // writes beyond the register list are dropped
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Tokenizer step: one item against the line state
   // ---------------------------------------------------------------------
   always_comb begin
      logic [LINE_LEN_BITS-1:0]    line_next;
      logic [FIELD_LEN_BITS-1:0]   field_next;
      logic [COUNT_LIMIT_BITS-1:0] count_next;

      line_next  = line_length_ff + LINE_LEN_BITS'(1);
      field_next = field_length_ff + FIELD_LEN_BITS'(1);
      count_next = field_count_ff + COUNT_LIMIT_BITS'(1);

      // hold the line state by default
      in_quotes_in    = in_quotes_ff;
      escape_in       = escape_ff;
      field_length_in = field_length_ff;
      line_length_in  = line_length_ff;
      field_count_in  = field_count_ff;
      line_error_in   = line_error_ff;

      emit        = 1'b0;
      out_char_in = '0;
      has_char_in = 1'b0;
      field_end_in = 1'b0;
      line_end_in = 1'b0;
      status_in   = ST_OK;

      if (req.kind == KIND_EOL) begin
         // report the line outcome and start a fresh line
         emit            = 1'b1;
         line_end_in     = 1'b1;
         field_end_in    = (line_error_ff == ST_OK);
         status_in       = line_error_ff;
         in_quotes_in    = 1'b0;
         escape_in       = 1'b0;
         field_length_in = '0;
         line_length_in  = '0;
         field_count_in  = '0;
         line_error_in   = ST_OK;
      end else if (line_error_ff == ST_OK) begin
         line_length_in = line_next;
         // line length is checked before anything else
         if (line_next > {1'b0, line_limit_ff}) begin
            emit          = 1'b1;
            status_in     = ST_LINE_LONG;
            line_error_in = ST_LINE_LONG;
         end else if (!escape_ff && req.char_code == BSL) begin
            escape_in = 1'b1;
         end else if (!escape_ff && req.char_code == QTE) begin
            in_quotes_in = !in_quotes_ff;
         end else if (!escape_ff && req.char_code == CMA && !in_quotes_ff) begin
            // close the field
            emit            = 1'b1;
            field_length_in = '0;
            field_count_in  = count_next;
            if (count_next >= count_limit_ff) begin
               status_in     = ST_TOO_MANY;
               line_error_in = ST_TOO_MANY;
            end else begin
               field_end_in = 1'b1;
            end
         end else begin
            // append the character, escaped or plain
            emit            = 1'b1;
            escape_in       = 1'b0;
            field_length_in = field_next;
            if (field_next > {1'b0, field_limit_ff}) begin
               status_in     = ST_FIELD_LONG;
               line_error_in = ST_FIELD_LONG;
            end else begin
               out_char_in = req.char_code;
               has_char_in = 1'b1;
            end
         end
      end

      // result register: load on a transfer, drain when taken
      if (req_fire) begin
         rsp_valid_in = emit;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // ---------------------------------------------------------------------
   // State and result registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_quotes_ff    <= 1'b0;
         escape_ff       <= 1'b0;
         field_length_ff <= '0;
         line_length_ff  <= '0;
         field_count_ff  <= '0;
         line_error_ff   <= ST_OK;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            in_quotes_ff    <= in_quotes_in;
            escape_ff       <= escape_in;
            field_length_ff <= field_length_in;
            line_length_ff  <= line_length_in;
            field_count_ff  <= field_count_in;
            line_error_ff   <= line_error_in;
         end
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (req_fire && emit) begin
         out_char_ff  <= out_char_in;
         has_char_ff  <= has_char_in;
         field_end_ff <= field_end_in;
         line_end_ff  <= line_end_in;
         status_ff    <= status_in;
      end
   end

`ifndef SYNTHESIS
   // a field character never travels with an error, a field end or a line end
   a_char_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && has_char_ff |-> status_ff == ST_OK && !field_end_ff && !line_end_ff)
      else $error("field character carries other flags");

   // a field end outside a line end only comes with ok status
   a_field_end_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && field_end_ff |-> status_ff == ST_OK)
      else $error("field end with error status");

   // end of line returns the line state to reset
   a_eol_clear: assert property (@(posedge clock) disable iff (reset)
      req_fire && req.kind == KIND_EOL |=>
         line_length_ff == '0 && field_count_ff == '0 && line_error_ff == ST_OK &&
         !in_quotes_ff && !escape_ff)
      else $error("line state not cleared after end of line");

   // after an error, characters of the line produce nothing
   a_drop_after_error: assert property (@(posedge clock) disable iff (reset)
      req_fire && req.kind == KIND_CHAR && line_error_ff != ST_OK |=> !rsp_valid_ff)
      else $error("result produced after line error");

   // an error is latched on the same transfer that reports it
   a_error_latched: assert property (@(posedge clock) disable iff (reset)
      req_fire && emit && status_in != ST_OK && !line_end_in |=> line_error_ff == status_ff)
      else $error("reported error not latched");
`endif

endmodule
